>>> src/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define PRQ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent on the following clock edge.
`define PRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent on the same clock edge.
`define PRQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> src/prq_pkg.sv
`timescale 1ns / 1ps

package prq_pkg;

  localparam int unsigned LEVELS = 32;
  localparam int unsigned TASKS  = 64;
  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned TID_W  = $clog2(TASKS);

  // Item opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Level table entry: head in the upper half, tail in the lower half
  typedef struct packed {
    logic [TID_W-1:0] head;
    logic [TID_W-1:0] tail;
  } lvl_entry_t;

  // Access to the level table
  typedef struct packed {
    logic             re;
    logic             we;
    logic [LVL_W-1:0] addr;
    lvl_entry_t       wdata;
  } lvl_req_t;

  // Access to the next-pointer table
  typedef struct packed {
    logic             re;
    logic             we;
    logic [TID_W-1:0] addr;
    logic [TID_W-1:0] wdata;
  } nxt_req_t;

  // Pop result handed to the output register
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [TID_W-1:0] task_id;
  } res_t;

  // Index of the lowest set bit; zero for an empty mask
  function automatic logic [LVL_W-1:0] lowest_set(input logic [LEVELS-1:0] mask);
    logic [LVL_W-1:0] idx;
    idx = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = LVL_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> src/prq_chan_if.sv
`timescale 1ns / 1ps

// Request channel: push or pop
interface prq_in_if import prq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [TID_W-1:0] task_id;
  logic [LVL_W-1:0] priority_req;

  modport source (output valid, op, task_id, priority_req, input ready);
  modport sink   (input valid, op, task_id, priority_req, output ready);
endinterface

// Result channel: one item per pop
interface prq_out_if import prq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [TID_W-1:0] popped_task;

  modport source (output valid, found, popped_task, input ready);
  modport sink   (input valid, found, popped_task, output ready);
endinterface

>>> src/prq_ram.sv
`timescale 1ns / 1ps

// Single-port synchronous RAM with registered read data
module prq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/prq_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: holds the level mask and runs the read-modify-write of both tables
module prq_ctrl import prq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [TID_W-1:0] task_id_i,
  input  logic [LVL_W-1:0] priority_req_i,
  input  logic             out_free_i,
  output lvl_req_t         lvl_req_o,
  input  lvl_entry_t       lvl_rdata_i,
  output nxt_req_t         nxt_req_o,
  input  logic [TID_W-1:0] nxt_rdata_i,
  output res_t             res_o,
  output logic             any_level_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PUSH   = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_POP_WB = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [LEVELS-1:0] mask_q, mask_d;
  logic [TID_W-1:0]  tid_q, tid_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic              found_q, found_d;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
    end
  end

  // Item payload, held while the item is worked on
  always_ff @(posedge clk_i) begin
    tid_q   <= tid_d;
    lvl_q   <= lvl_d;
    found_q <= found_d;
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    tid_d      = tid_q;
    lvl_d      = lvl_q;
    found_d    = found_q;
    in_ready_o = 1'b0;
    lvl_req_o  = '0;
    nxt_req_o  = '0;
    res_o      = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          tid_d = task_id_i;
          if (op_i == OP_PUSH) begin
            // fetch head/tail of the target level
            lvl_d          = priority_req_i;
            lvl_req_o.re   = 1'b1;
            lvl_req_o.addr = priority_req_i;
            state_d        = S_PUSH;
          end else begin
            // pick the lowest non-empty level and fetch its pointers
            lvl_d          = lowest_set(mask_q);
            found_d        = |mask_q;
            lvl_req_o.re   = |mask_q;
            lvl_req_o.addr = lowest_set(mask_q);
            state_d        = S_POP;
          end
        end
      end

      S_PUSH: begin
        lvl_req_o.we         = 1'b1;
        lvl_req_o.addr       = lvl_q;
        lvl_req_o.wdata.tail = tid_q;
        if (mask_q[lvl_q]) begin
          // link after the old tail
          lvl_req_o.wdata.head = lvl_rdata_i.head;
          nxt_req_o.we         = 1'b1;
          nxt_req_o.addr       = lvl_rdata_i.tail;
          nxt_req_o.wdata      = tid_q;
        end else begin
          lvl_req_o.wdata.head = tid_q;
          mask_d[lvl_q]        = 1'b1;
        end
        state_d = S_IDLE;
      end

      S_POP: begin
        // wait for a free output slot, then report the head, or not found
        if (out_free_i) begin
          res_o.valid   = 1'b1;
          res_o.found   = found_q;
          res_o.task_id = found_q ? lvl_rdata_i.head : '0;
          if (!found_q) begin
            state_d = S_IDLE;
          end else if (lvl_rdata_i.head == lvl_rdata_i.tail) begin
            mask_d[lvl_q] = 1'b0;
            state_d       = S_IDLE;
          end else begin
            nxt_req_o.re   = 1'b1;
            nxt_req_o.addr = lvl_rdata_i.head;
            state_d        = S_POP_WB;
          end
        end
      end

      S_POP_WB: begin
        // advance the head; tail read data is still held in the RAM output
        lvl_req_o.we         = 1'b1;
        lvl_req_o.addr       = lvl_q;
        lvl_req_o.wdata.head = nxt_rdata_i;
        lvl_req_o.wdata.tail = lvl_rdata_i.tail;
        state_d              = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign any_level_o = |mask_q;

endmodule

>>> src/priority_ready_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Multi-level ready queue: one FIFO of task ids per priority level (0 is served
// first), kept as linked lists in a next-pointer RAM indexed by task id, with
// head/tail pointers per level in a second RAM and a flop mask of non-empty
// levels. A push (op 0) appends task_id to level priority_req and gives no
// result; a pop (op 1) removes the head of the lowest non-empty level and
// gives one result item (found = 0, popped_task = 0 when every level is empty).
// One item is worked on at a time: a push reads the level's head/tail pointers
// and writes them back, and a pop reads them and gives its result, then, when
// the head pointer must be advanced, reads the next pointer and writes the new
// head back. The result sits in an output register, so the next item is
// taken while it waits; a pop holds in the S_POP state for as long as the
// previous result is still waiting there. Pushing a task that is already
// queued corrupts the lists and is not checked. No clearing pass is needed
// after reset.
module priority_ready_queue import prq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  prq_in_if.sink     in_i,
  prq_out_if.source  out_o
);

  lvl_req_t         lvl_req;
  lvl_entry_t       lvl_rdata;
  nxt_req_t         nxt_req;
  logic [TID_W-1:0] nxt_rdata;
  res_t             res;
  logic             any_level;
  logic             out_free;

  logic             out_valid_q;
  logic             out_found_q;
  logic [TID_W-1:0] out_task_q;

  assign out_free = !out_valid_q || out_o.ready;

  prq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .op_i           (in_i.op),
    .task_id_i      (in_i.task_id),
    .priority_req_i (in_i.priority_req),
    .out_free_i     (out_free),
    .lvl_req_o      (lvl_req),
    .lvl_rdata_i    (lvl_rdata),
    .nxt_req_o      (nxt_req),
    .nxt_rdata_i    (nxt_rdata),
    .res_o          (res),
    .any_level_o    (any_level)
  );

  // Per-level head/tail pointers
  prq_ram #(
    .WIDTH (2 * TID_W),
    .DEPTH (LEVELS)
  ) u_lvl_ram (
    .clk_i   (clk_i),
    .re_i    (lvl_req.re),
    .we_i    (lvl_req.we),
    .addr_i  (lvl_req.addr),
    .wdata_i (lvl_req.wdata),
    .rdata_o (lvl_rdata)
  );

  // Per-task next pointers
  prq_ram #(
    .WIDTH (TID_W),
    .DEPTH (TASKS)
  ) u_nxt_ram (
    .clk_i   (clk_i),
    .re_i    (nxt_req.re),
    .we_i    (nxt_req.we),
    .addr_i  (nxt_req.addr),
    .wdata_i (nxt_req.wdata),
    .rdata_o (nxt_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_found_q <= res.found;
      out_task_q  <= res.task_id;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.popped_task = out_task_q;

  // Checks
  `PRQ_ASSERT_IMPL(a_res_slot_free, res.valid, out_free)
  `PRQ_ASSERT_IMPL(a_empty_pop_no_level, res.valid && !res.found, !any_level)
  `PRQ_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready)
  `PRQ_ASSERT(a_no_ram_conflict, !(lvl_req.re && lvl_req.we) && !(nxt_req.re && nxt_req.we))

endmodule
